// ===== hw/rtl/ils_pkg.sv =====
// Package for the indexed list store: transaction structs, action and status
// codes, cell control codes and default sizes.
// No dependencies.
package ils_pkg;

   // Default sizes handed to the top level parameters
   localparam int CAPACITY_DEFAULT  = 256;
   localparam int WORD_BITS_DEFAULT = 32;

   // Wide enough for a position or count at any capacity up to 4096
   localparam int POS_BITS = 13;

   // Actions
   localparam logic [2:0] ACT_GET    = 3'd0;
   localparam logic [2:0] ACT_SET    = 3'd1;
   localparam logic [2:0] ACT_PUSH   = 3'd2;
   localparam logic [2:0] ACT_POP    = 3'd3;
   localparam logic [2:0] ACT_INSERT = 3'd4;
   localparam logic [2:0] ACT_REMOVE = 3'd5;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // Cell modes, broadcast to every cell of the chain
   localparam logic [2:0] CM_HOLD   = 3'd0;  // keep word
   localparam logic [2:0] CM_WRITE  = 3'd1;  // target cell loads value
   localparam logic [2:0] CM_INSERT = 3'd2;  // target loads value, cells above take left word
   localparam logic [2:0] CM_REMOVE = 3'd3;  // target and cells above take right word
   localparam logic [2:0] CM_ZERO   = 3'd4;  // target cell cleared
   localparam logic [2:0] CM_CLEAR  = 3'd5;  // every cell cleared

   typedef struct packed {
      logic [2:0]  action;
      logic [8:0]  index;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic [1:0]  status;
      logic [8:0]  length;
   } rsp_type;

   typedef struct packed {
      logic [2:0]          mode;
      logic [POS_BITS-1:0] tgt;  // target position
      logic [POS_BITS-1:0] cnt;  // list length before the action
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/ils_cell.sv =====
// One storage cell of the indexed list store chain.
// Holds one word and takes its neighbor's word on insert or remove shifts.
// Depends on ils_pkg.
module ils_cell #(
   parameter int POS       = 0,
   parameter int WORD_BITS = ils_pkg::WORD_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ils_pkg::cell_ctrl_type      ctrl,
   input  logic [WORD_BITS-1:0]        value,
   input  logic [WORD_BITS-1:0]        left_word,
   input  logic [WORD_BITS-1:0]        right_word,
   output logic [WORD_BITS-1:0]        word,
   output logic [WORD_BITS-1:0]        rd_word
);

   localparam logic [ils_pkg::POS_BITS-1:0] MY_POS = ils_pkg::POS_BITS'(POS);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 is_tgt;

   assign is_tgt = (ctrl.tgt == MY_POS);

   always_comb begin
      word_in = word_ff;
      case (ctrl.mode)
         ils_pkg::CM_HOLD: begin
            word_in = word_ff;
         end
         ils_pkg::CM_WRITE: begin
            if (is_tgt) word_in = value;
         end
         ils_pkg::CM_INSERT: begin
            if (is_tgt) word_in = value;
            else if (MY_POS > ctrl.tgt && MY_POS <= ctrl.cnt) word_in = left_word;
         end
         ils_pkg::CM_REMOVE: begin
            // entries at and past the length are zero, so the top one pulls in zero
            if (MY_POS >= ctrl.tgt && MY_POS < ctrl.cnt) word_in = right_word;
         end
         ils_pkg::CM_ZERO: begin
            if (is_tgt) word_in = '0;
         end
         ils_pkg::CM_CLEAR: begin
            word_in = '0;
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) word_ff <= '0;
      else       word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = is_tgt ? word_ff : '0;

endmodule

// ===== hw/rtl/indexed_list_store.sv =====
// Indexed list store top level: request decode, length register and the
// chain of ils_cell storage cells. Depends on ils_pkg and ils_cell.
//
// A fixed-capacity ordered list of CAPACITY words. Each transaction asks for
// get, set, push, pop, insert (later entries move up) or remove (later
// entries move down) and returns one result: the word read or removed, a
// status (ok, index out of range, full, empty) and the length afterwards.
// A failed action changes nothing and returns a zero word. Every word lives
// in a cell of its own that is linked to both neighbors, so an insert or
// remove shifts the whole list in one update. A transaction is taken at
// a clock edge with start high and busy low; busy is then high for one cycle
// while the chain updates, and the result appears on rsp for one cycle,
// marked by rsp_valid, after the request register and the result register.
// The result cannot be stalled, so it must be captured in that cycle. No new
// transaction is accepted while busy: the request is registered, then the
// chain updates and the read runs across all cells. Writing csr_data sets
// the length to that value (capped at CAPACITY) and clears every entry;
// csr_ready is low while busy. Reset clears the list to length zero.
module indexed_list_store #(
   parameter int CAPACITY  = ils_pkg::CAPACITY_DEFAULT,
   parameter int WORD_BITS = ils_pkg::WORD_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             start,
   output logic             busy,
   input  ils_pkg::req_type req,
   // result channel
   output logic             rsp_valid,
   output ils_pkg::rsp_type rsp,
   // configuration write: initial length
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [8:0]       csr_data
);

   localparam int PB       = ils_pkg::POS_BITS;
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam logic [PB-1:0] CAP = PB'(CAPACITY);

   // request stage
   logic             req_valid_ff;
   ils_pkg::req_type req_ff;

   // list length
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   // result stage
   logic             rsp_valid_ff;
   ils_pkg::rsp_type rsp_ff;
   ils_pkg::rsp_type rsp_in;

   // chain
   ils_pkg::cell_ctrl_type ctrl;
   logic [WORD_BITS-1:0]   cell_value;
   logic [WORD_BITS-1:0]   cell_word [CAPACITY];
   logic [WORD_BITS-1:0]   cell_rd   [CAPACITY];
   logic [WORD_BITS-1:0]   rd_or;
   logic [63:0]            value64;
   logic [63:0]            rd64;

   logic [PB-1:0] cnt;
   logic [PB-1:0] idx;
   logic [PB-1:0] new_cnt;
   logic [PB-1:0] csr_len;
   logic [1:0]    status;
   logic          do_read;
   logic          cfg_write;

   assign busy      = req_valid_ff;
   assign csr_ready = ~req_valid_ff;
   assign cfg_write = csr_valid & csr_ready;

   assign cnt     = PB'(count_ff);
   assign idx     = PB'(req_ff.index);
   assign value64 = {32'b0, req_ff.value};
   assign cell_value = value64[WORD_BITS-1:0];
   assign csr_len = (PB'(csr_data) > CAP) ? CAP : PB'(csr_data);

   // decode a configuration write or the registered transaction into a broadcast cell command
   always_comb begin
      ctrl.mode = ils_pkg::CM_HOLD;
      ctrl.tgt  = idx;
      ctrl.cnt  = cnt;
      new_cnt   = cnt;
      status    = ils_pkg::ST_OK;
      do_read   = 1'b0;
      if (cfg_write) begin
         ctrl.mode = ils_pkg::CM_CLEAR;
      end else if (req_valid_ff) begin
         case (req_ff.action)
            ils_pkg::ACT_GET: begin
               if (idx < cnt) do_read = 1'b1;
               else           status  = ils_pkg::ST_RANGE;
            end
            ils_pkg::ACT_SET: begin
               if (idx < cnt) ctrl.mode = ils_pkg::CM_WRITE;
               else           status    = ils_pkg::ST_RANGE;
            end
            ils_pkg::ACT_PUSH: begin
               if (cnt >= CAP) begin
                  status = ils_pkg::ST_FULL;
               end else begin
                  ctrl.mode = ils_pkg::CM_WRITE;
                  ctrl.tgt  = cnt;
                  new_cnt   = cnt + 1'b1;
               end
            end
            ils_pkg::ACT_POP: begin
               if (cnt == '0) begin
                  status = ils_pkg::ST_EMPTY;
               end else begin
                  ctrl.mode = ils_pkg::CM_ZERO;
                  ctrl.tgt  = cnt - 1'b1;
                  new_cnt   = cnt - 1'b1;
                  do_read   = 1'b1;
               end
            end
            ils_pkg::ACT_INSERT: begin
               // range is checked before fullness
               if (idx > cnt) begin
                  status = ils_pkg::ST_RANGE;
               end else if (cnt >= CAP) begin
                  status = ils_pkg::ST_FULL;
               end else begin
                  ctrl.mode = ils_pkg::CM_INSERT;
                  new_cnt   = cnt + 1'b1;
               end
            end
            ils_pkg::ACT_REMOVE: begin
               if (idx >= cnt) begin
                  status = ils_pkg::ST_RANGE;
               end else begin
                  ctrl.mode = ils_pkg::CM_REMOVE;
                  new_cnt   = cnt - 1'b1;
                  do_read   = 1'b1;
               end
            end
            default: begin
               // unused action codes: nothing changes
               status = ils_pkg::ST_OK;
            end
         endcase
      end
   end

   // chain of cells, each linked to both neighbors
   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;
      if (j == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = cell_word[j-1];
      end
      if (j == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = cell_word[j+1];
      end
      ils_cell #(
         .POS       (j),
         .WORD_BITS (WORD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .value      (cell_value),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[j]),
         .rd_word    (cell_rd[j])
      );
   end

   // only the target cell drives a nonzero read word
   always_comb begin
      rd_or = '0;
      for (int k = 0; k < CAPACITY; k++) rd_or = rd_or | cell_rd[k];
   end

   assign rd64 = 64'(rd_or);

   always_comb begin
      rsp_in.read_value = do_read ? rd64[31:0] : 32'b0;
      rsp_in.status     = status;
      rsp_in.length     = new_cnt[8:0];
   end

   always_comb begin
      count_in = count_ff;
      if (cfg_write)         count_in = CNT_BITS'(csr_len);
      else if (req_valid_ff) count_in = CNT_BITS'(new_cnt);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         req_valid_ff <= start & ~req_valid_ff;
         rsp_valid_ff <= req_valid_ff;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start & ~req_valid_ff) req_ff <= req;
      if (req_valid_ff)          rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // a request occupies the chain for exactly one cycle
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff |=> !req_valid_ff)
      else $error("busy held for more than one cycle");

   // every result follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a transaction");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      PB'(count_ff) <= CAP)
      else $error("length exceeds capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ils_pkg::ST_FULL) |-> rsp.length == CAP[8:0])
      else $error("full status with list not full");

   a_empty_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.status == ils_pkg::ST_EMPTY) |-> rsp.length == 9'd0)
      else $error("empty status with list not empty");

endmodule
